/* hdl/bscc_pkg.sv */
`default_nettype none

package bscc_pkg;

   localparam logic [7:0] CH_ESC        = 8'd27;
   localparam logic [7:0] CH_BRACKET    = 8'h5B;
   localparam logic [7:0] CH_PARAM_LO   = 8'h30;
   localparam logic [7:0] CH_PARAM_HI   = 8'h3F;
   localparam logic [7:0] CH_INTER_LO   = 8'h20;
   localparam logic [7:0] CH_INTER_HI   = 8'h2F;
   localparam logic [7:0] CH_FINAL_LO   = 8'h40;
   localparam logic [7:0] CH_FINAL_HI   = 8'h7E;
   localparam logic [7:0] CH_PRINT_LO   = 8'd32;
   localparam logic [7:0] CH_PRINT_HI   = 8'd126;
   localparam logic [7:0] CH_BELL       = 8'd7;
   localparam logic [7:0] CH_BACKSPACE  = 8'd8;
   localparam logic [7:0] CH_TAB        = 8'd9;
   localparam logic [7:0] CH_LF         = 8'd10;
   localparam logic [7:0] CH_CR         = 8'd13;

   localparam logic [2:0] CLS_PRINTABLE   = 3'd0;
   localparam logic [2:0] CLS_ALL_NULL    = 3'd1;
   localparam logic [2:0] CLS_IDENTICAL   = 3'd2;
   localparam logic [2:0] CLS_ALTERNATING = 3'd3;
   localparam logic [2:0] CLS_NONE        = 3'd4;

   typedef enum logic [3:0] {
      PH_NORMAL = 4'b0001,
      PH_ESC    = 4'b0010,
      PH_PARAM  = 4'b0100,
      PH_INTER  = 4'b1000
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic       printable;
      logic       all_null;
      logic       identical;
      logic       alternating;
      logic [7:0] ref_byte;
      logic       prev_null;
      logic       trailing_null;
      logic       seen_first;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:         PH_NORMAL,
      printable:     1'b1,
      all_null:      1'b1,
      identical:     1'b1,
      alternating:   1'b1,
      ref_byte:      8'd0,
      prev_null:     1'b0,
      trailing_null: 1'b0,
      seen_first:    1'b0
   };

endpackage

`default_nettype wire

/* hdl/bscc_step.sv */
`default_nettype none

module bscc_step (
   input  wire bscc_pkg::state_type state,
   input  wire logic [7:0]          byte_value,
   input  wire logic                last_byte,
   output bscc_pkg::state_type      state_next,
   output logic [2:0]               class_code
);
   import bscc_pkg::*;

   function automatic logic is_allowed(logic [7:0] c);
      logic r;
      r = (c == CH_BELL) || (c == CH_BACKSPACE) || (c == CH_TAB) || (c == CH_LF) ||
          (c == CH_CR) || ((c >= CH_PRINT_LO) && (c <= CH_PRINT_HI));
      return r;
   endfunction

   function automatic state_type plain_update(state_type s, logic [7:0] c);
      logic      first;
      state_type r;
      r     = s;
      first = !s.seen_first;
      if (first) begin
         r.prev_null = (c == 8'd0);
      end
      r.seen_first = 1'b1;
      if (c != 8'd0) begin
         r.all_null = 1'b0;
      end
      if (!first && s.identical && (c != s.ref_byte)) begin
         r.identical = 1'b0;
      end else if (s.identical) begin
         r.ref_byte = c;
      end
      if (!first && s.alternating) begin
         if (c != 8'd0) begin
            if (s.trailing_null || !s.prev_null) begin
               r.alternating = 1'b0;
            end
         end else if (!s.trailing_null && s.prev_null) begin
            r.trailing_null = 1'b1;
         end
         r.prev_null = !s.prev_null;
      end
      return r;
   endfunction

   function automatic state_type normal_byte(state_type s, logic [7:0] c);
      state_type r;
      r = plain_update(s, c);
      if (c == CH_ESC) begin
         r.phase = PH_ESC;
      end else if (!is_allowed(c)) begin
         r.printable = 1'b0;
      end
      return r;
   endfunction

   function automatic state_type csi_fail(state_type s);
      state_type r;
      r             = s;
      r.printable   = 1'b0;
      r.all_null    = 1'b0;
      r.identical   = 1'b0;
      r.alternating = 1'b0;
      r.phase       = PH_NORMAL;
      return r;
   endfunction

   function automatic state_type csi_done(state_type s);
      state_type r;
      r             = s;
      r.identical   = 1'b0;
      r.alternating = 1'b0;
      r.phase       = PH_NORMAL;
      return r;
   endfunction

   state_type upd;
   state_type fin;
   logic      is_param;
   logic      is_inter;
   logic      is_final;

   assign is_param = (byte_value >= CH_PARAM_LO) && (byte_value <= CH_PARAM_HI);
   assign is_inter = (byte_value >= CH_INTER_LO) && (byte_value <= CH_INTER_HI);
   assign is_final = (byte_value >= CH_FINAL_LO) && (byte_value <= CH_FINAL_HI);

   always_comb begin
      upd = state;
      case (state.phase)
         PH_ESC: begin
            if (byte_value == CH_BRACKET) begin
               upd.phase = PH_PARAM;
            end else begin
               upd           = state;
               upd.printable = 1'b0;
               upd.phase     = PH_NORMAL;
               upd           = normal_byte(upd, byte_value);
            end
         end
         PH_PARAM: begin
            if (is_param) begin
               upd = state;
            end else if (is_inter) begin
               upd.phase = PH_INTER;
            end else if (is_final) begin
               upd = csi_done(state);
            end else begin
               upd = csi_fail(state);
            end
         end
         PH_INTER: begin
            if (is_inter) begin
               upd = state;
            end else if (is_final) begin
               upd = csi_done(state);
            end else begin
               upd = csi_fail(state);
            end
         end
         default: begin
            upd = normal_byte(state, byte_value);
         end
      endcase
   end

   // At the end of the stream a pending ESC counts as an ordinary byte and an
   // open control sequence counts as failed.
   always_comb begin
      fin = upd;
      if (upd.phase == PH_ESC) begin
         fin.printable = 1'b0;
      end else if (upd.phase != PH_NORMAL) begin
         fin = csi_fail(upd);
      end
   end

   always_comb begin
      if (fin.printable) begin
         class_code = CLS_PRINTABLE;
      end else if (fin.all_null) begin
         class_code = CLS_ALL_NULL;
      end else if (fin.identical) begin
         class_code = CLS_IDENTICAL;
      end else if (fin.alternating) begin
         class_code = CLS_ALTERNATING;
      end else begin
         class_code = CLS_NONE;
      end
   end

   assign state_next = last_byte ? STATE_RESET : upd;

endmodule

`default_nettype wire

/* hdl/byte_stream_content_classifier.sv */
// Classifies a byte stream, one beat per byte, and returns one class code on
// the beat after the byte marked last: printable text, all null, all
// identical, nulls alternating with nonzero bytes, or none. ANSI control
// sequences pass the printable test but rule out identical and alternating;
// bad ones give none. A byte is taken every cycle; the per-byte flag update
// is short combinational logic in front of the state register, and the class
// lands in an output register. While a finished class is held there and the
// receiver is not ready, the input stalls; a receiver that keeps up never
// slows the stream. After the last byte it is ready for a new stream at once.
`default_nettype none

module byte_stream_content_classifier (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_byte_value,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_class_code
);
   import bscc_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   state_type  step_next;
   logic [2:0] step_class;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [2:0] class_ff;
   logic [2:0] class_in;
   logic       req_fire;
   logic       emit;

   bscc_step u_step (
      .state      (state_ff),
      .byte_value (req_byte_value),
      .last_byte  (req_last_byte),
      .state_next (step_next),
      .class_code (step_class)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign emit      = req_fire && req_last_byte;

   always_comb begin
      state_in     = req_fire ? step_next : state_ff;
      class_in     = emit ? step_class : class_ff;
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      class_ff <= class_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_class_code = class_ff;

`ifndef SYNTHESIS
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(req_valid && req_ready && req_last_byte))
      else $error("class beat without an accepted last byte");

   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_class_code <= CLS_NONE))
      else $error("class code out of range");

   a_stream_restart: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_byte) |=> (state_ff == STATE_RESET))
      else $error("stream state not cleared after last byte");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no class pending");
`endif

endmodule

`default_nettype wire
